/* src/rsta_pkg.sv */
// ----------------------------------------------------------------------------
// rsta_pkg
// Shared types and codes for the rotating slot tag allocator.
// ----------------------------------------------------------------------------
package rsta_pkg;

  // action codes carried in tuser of the input stream
  localparam logic [2:0] ACT_ALLOC    = 3'd0;
  localparam logic [2:0] ACT_RELEASE  = 3'd1;
  localparam logic [2:0] ACT_MARK     = 3'd2;
  localparam logic [2:0] ACT_COMPLETE = 3'd3;
  localparam logic [2:0] ACT_QUERY    = 3'd4;

  // status codes carried in tuser of the output stream
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NO_SLOT = 2'd1;
  localparam logic [1:0] STS_RANGE   = 2'd2;

  localparam int unsigned TagW  = 32;
  localparam int unsigned SlotW = 7;

  // one entry of the slot table
  typedef struct packed {
    logic busy;
    logic ready;
  } rsta_ent_t;

  // one result word
  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] slot_out;
    logic [TagW-1:0]  tag_out;
    logic             ready_res;
  } rsta_res_t;

endpackage

/* src/rsta_rem.sv */
// ----------------------------------------------------------------------------
// rsta_rem
// Trace tag mod SLOTS in three pipelined steps: fold the upper half onto the
// lower one, reciprocal multiply for the quotient, subtract back for the
// remainder.
// ----------------------------------------------------------------------------
module rsta_rem #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [31:0]              dividend_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] rem_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned FW = 26;           // width after the fold
  localparam int unsigned PW = 2 * FW + 1;   // quotient product width
  localparam int unsigned SH = FW + AW;
  // 2^16 mod SLOTS; hi * K + lo keeps the residue and stays below 2^26
  localparam logic [FW-1:0] FOLD_K = FW'((64'd1 << 16) % 64'(SLOTS));
  // floor(2^SH / SLOTS) + 1 gives the exact quotient for any value below 2^FW
  localparam logic [PW-1:0] RECIP  = PW'(((64'd1 << SH) / 64'(SLOTS)) + 64'd1);

  logic [FW-1:0] fold_q, fold_d;
  logic [FW-1:0] quo_q, quo_d;
  logic [AW-1:0] rem_q, rem_d;
  logic [PW-1:0] prod;
  logic [FW-1:0] back;
  logic          fold_vld_q;
  logic          quo_vld_q;
  logic          done_q;

  always_comb begin
    fold_d = FW'(dividend_i[15:0]) + FW'(dividend_i[31:16]) * FOLD_K;
    prod   = PW'(fold_q) * RECIP;
    quo_d  = FW'(prod >> SH);
    back   = fold_q - quo_q * FW'(SLOTS);
    rem_d  = back[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
      quo_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      fold_vld_q <= start_i;
      quo_vld_q  <= fold_vld_q;
      done_q     <= quo_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fold_q <= fold_d;
    end
    if (fold_vld_q) begin
      quo_q <= quo_d;
    end
    if (quo_vld_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* src/rsta_table.sv */
// ----------------------------------------------------------------------------
// rsta_table
// Slot table: busy and ready bits per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module rsta_table #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  rsta_pkg::rsta_ent_t      wdata_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output rsta_pkg::rsta_ent_t      rdata_o
);

  import rsta_pkg::*;

  rsta_ent_t mem [SLOTS];
  rsta_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/rotating_slot_tag_allocator_unit.sv */
// ----------------------------------------------------------------------------
// rotating_slot_tag_allocator_unit
// Round-robin tag allocator over a table of SLOTS request slots.
// ----------------------------------------------------------------------------
// Takes one word at a time and returns one result word for each. After reset
// the slot table is swept clean before the first word is taken. Allocate
// probes one slot per cycle from the running counter, examining at most
// SLOTS slots. Release and mark waiting read the slot and write it back,
// query only reads it; complete first passes through the pipelined
// remainder unit that maps the trace tag onto a slot, then reads and writes
// it. Undefined actions and out-of-range slots go straight to the result.
// The input is not ready until the result has been taken.
module rotating_slot_tag_allocator_unit #(
  parameter int unsigned SLOTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // action
  input  logic [39:0] s_axis_tdata,   // slot[6:0], trace_tag[38:7], pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // status
  output logic [39:0] m_axis_tdata    // slot_out[6:0], tag_out[38:7], ready_res
);

  import rsta_pkg::*;

  localparam int unsigned AW = $clog2(SLOTS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ALLOC = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // next slot index for a counter step; a counter wrap restarts at slot zero
  function automatic logic [AW-1:0] nxt_idx(input logic [AW-1:0] idx,
                                            input logic [31:0]   cnt);
    logic wrap;
    wrap = (cnt == 32'hFFFF_FFFF) || (idx == AW'(SLOTS - 1));
    return wrap ? '0 : idx + AW'(1);
  endfunction

  logic [2:0]    state_q, state_d;
  logic [2:0]    act_q, act_d;
  logic [31:0]   ctr_q, ctr_d;
  logic [AW-1:0] idx_q, idx_d;       // always ctr_q mod SLOTS
  logic [31:0]   cand_cnt_q, cand_cnt_d;
  logic [AW-1:0] cand_idx_q, cand_idx_d;
  logic [AW-1:0] ahead_q, ahead_d;   // slot being read for the next probe
  logic [AW-1:0] probe_q, probe_d;
  logic [AW-1:0] op_idx_q, op_idx_d;
  rsta_res_t     res_q, res_d;

  logic          in_acc;
  logic [2:0]    in_act;
  logic [6:0]    in_slot;
  logic [31:0]   in_tag;
  logic [31:0]   cand_inc;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  rsta_ent_t     tbl_wdata;
  logic [AW-1:0] tbl_raddr;
  rsta_ent_t     tbl_rdata;

  logic          rem_start;
  logic          rem_done;
  logic [AW-1:0] rem_val;

  assign in_act  = s_axis_tuser;
  assign in_slot = s_axis_tdata[6:0];
  assign in_tag  = s_axis_tdata[38:7];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cand_inc = cand_cnt_q + 32'd1;

  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    ctr_d      = ctr_q;
    idx_d      = idx_q;
    cand_cnt_d = cand_cnt_q;
    cand_idx_d = cand_idx_q;
    ahead_d    = ahead_q;
    probe_d    = probe_q;
    op_idx_d   = op_idx_q;
    res_d      = res_q;
    tbl_we     = 1'b0;
    tbl_waddr  = op_idx_q;
    tbl_wdata  = tbl_rdata;
    tbl_raddr  = op_idx_q;
    rem_start  = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_wdata = '{busy: 1'b0, ready: 1'b1};
        op_idx_d  = op_idx_q + AW'(1);
        if (op_idx_q == AW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        tbl_raddr = idx_q;
        if (in_acc) begin
          act_d = in_act;
          case (in_act) inside
            ACT_ALLOC: begin
              cand_cnt_d = ctr_q;
              cand_idx_d = idx_q;
              ahead_d    = nxt_idx(idx_q, ctr_q);
              probe_d    = '0;
              state_d    = ST_ALLOC;
            end
            ACT_RELEASE, ACT_MARK, ACT_QUERY: begin
              if (32'(in_slot) >= 32'(SLOTS)) begin
                res_d   = '{status: STS_RANGE, slot_out: in_slot,
                            tag_out: '0, ready_res: 1'b0};
                state_d = ST_OUT;
              end else begin
                op_idx_d = AW'(in_slot);
                state_d  = ST_READ;
              end
            end
            ACT_COMPLETE: begin
              rem_start = 1'b1;
              state_d   = ST_MOD;
            end
            default: begin
              res_d   = '0;
              state_d = ST_OUT;
            end
          endcase
        end
      end

      ST_ALLOC: begin
        // read data belongs to cand_idx_q; the table reads one slot ahead
        tbl_raddr = ahead_q;
        if (!tbl_rdata.busy) begin
          tbl_we    = 1'b1;
          tbl_waddr = cand_idx_q;
          tbl_wdata = '{busy: 1'b1, ready: tbl_rdata.ready};
          ctr_d     = cand_inc;
          idx_d     = ahead_q;
          res_d     = '{status: STS_OK, slot_out: SlotW'(cand_idx_q),
                        tag_out: cand_cnt_q, ready_res: tbl_rdata.ready};
          state_d   = ST_OUT;
        end else if (probe_q == AW'(SLOTS - 1)) begin
          res_d   = '{status: STS_NO_SLOT, slot_out: '0, tag_out: '0,
                      ready_res: 1'b0};
          state_d = ST_OUT;
        end else begin
          cand_cnt_d = cand_inc;
          cand_idx_d = ahead_q;
          ahead_d    = nxt_idx(ahead_q, cand_inc);
          probe_d    = probe_q + AW'(1);
        end
      end

      ST_MOD: begin
        if (rem_done) begin
          op_idx_d = rem_val;
          state_d  = ST_READ;
        end
      end

      ST_READ: begin
        state_d = ST_WRITE;
      end

      ST_WRITE: begin
        res_d = '{status: STS_OK, slot_out: SlotW'(op_idx_q), tag_out: '0,
                  ready_res: tbl_rdata.ready};
        case (act_q)
          ACT_RELEASE: begin
            tbl_we    = 1'b1;
            tbl_wdata = '{busy: 1'b0, ready: tbl_rdata.ready};
          end
          ACT_MARK: begin
            tbl_we          = 1'b1;
            tbl_wdata       = '{busy: tbl_rdata.busy, ready: 1'b0};
            res_d.ready_res = 1'b0;
          end
          ACT_COMPLETE: begin
            tbl_we          = 1'b1;
            tbl_wdata       = '{busy: tbl_rdata.busy, ready: 1'b1};
            res_d.ready_res = 1'b1;
          end
          default: begin
          end
        endcase
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ctr_q    <= '0;
      idx_q    <= '0;
      op_idx_q <= '0;
      probe_q  <= '0;
    end else begin
      state_q  <= state_d;
      ctr_q    <= ctr_d;
      idx_q    <= idx_d;
      op_idx_q <= op_idx_d;
      probe_q  <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    cand_cnt_q <= cand_cnt_d;
    cand_idx_q <= cand_idx_d;
    ahead_q    <= ahead_d;
    res_q      <= res_d;
  end

  rsta_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  rsta_rem #(
    .SLOTS (SLOTS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (in_tag),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {res_q.ready_res, res_q.tag_out, res_q.slot_out};

endmodule
